@@ sv/dlh_pkg.sv @@
// Package for the line hull maximum block: item, carry and state types.
// No dependencies; used by dlh_cell and dynamic_line_hull_max_query.
package dlh_pkg;

    localparam int LineCapacityDefault = 64;

    localparam int SlopeW  = 24;
    localparam int IcptW   = 47;
    localparam int CoordW  = 24;
    localparam int ValueW  = 48;
    localparam int InDataW = 96;   // 95 bits of fields, zero filled to bytes
    localparam int InUserW = 1;
    localparam int OutDataW = 48;
    localparam int OutUserW = 2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // item held for the whole walk and broadcast to every cell
    typedef struct packed {
        logic                     op;
        logic signed [SlopeW-1:0] slope;
        logic signed [IcptW-1:0]  intercept;
        logic signed [CoordW-1:0] query_x;
    } item_t;

    // token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     hit;      // query: line seen; insert: slope matched
        logic signed [ValueW-1:0] best;
        logic                     free_ok;  // insert: a free entry was found
    } carry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_INJECT,
        ST_WALK,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

@@ sv/dlh_cell.sv @@
// One line cell of the hull chain: stores a line, evaluates it at the broadcast x
// and updates the passing token. Depends on dlh_pkg.
module dlh_cell #(
    parameter int LINE_CAPACITY = dlh_pkg::LineCapacityDefault,
    parameter int INDEX         = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dlh_pkg::item_t                   item,
    input  logic                             wr_en,
    input  logic [$clog2(LINE_CAPACITY)-1:0] wr_idx,
    input  dlh_pkg::carry_t                  carry_in,
    input  logic [$clog2(LINE_CAPACITY)-1:0] free_idx_in,
    output dlh_pkg::carry_t                  carry_out,
    output logic [$clog2(LINE_CAPACITY)-1:0] free_idx_out
);
    import dlh_pkg::*;

    localparam int IdxW = $clog2(LINE_CAPACITY);
    localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

    logic                     used_reg;
    logic signed [SlopeW-1:0] slope_reg;
    logic signed [IcptW-1:0]  icpt_reg;
    logic signed [ValueW-1:0] prod_reg;
    logic signed [ValueW-1:0] prod_next;
    logic signed [ValueW-1:0] value_reg;
    logic signed [ValueW-1:0] value_next;
    carry_t                   carry_reg;
    carry_t                   carry_next;
    logic [IdxW-1:0]          free_idx_reg;
    logic [IdxW-1:0]          free_idx_next;
    logic                     slope_match;
    logic                     load_line;
    logic                     raise_icpt;

    // evaluate the stored line at the broadcast x, one register per step
    assign prod_next  = ValueW'($signed(slope_reg)) * ValueW'($signed(item.query_x));
    assign value_next = prod_reg + ValueW'($signed(icpt_reg));

    assign slope_match = used_reg && (slope_reg == item.slope);
    assign load_line   = wr_en && (wr_idx == MyIdx);
    assign raise_icpt  = carry_in.valid && (item.op == OP_INSERT) && slope_match
                         && (item.intercept > icpt_reg);

    // update the token as it passes this cell
    always_comb
    begin
        carry_next    = carry_in;
        free_idx_next = free_idx_in;
        if (carry_in.valid)
        begin
            if (item.op == OP_QUERY)
            begin
                if (used_reg && (!carry_in.hit || value_reg > carry_in.best))
                begin
                    carry_next.hit  = 1'b1;
                    carry_next.best = value_reg;
                end
            end
            else
            begin
                if (slope_match)
                begin
                    carry_next.hit = 1'b1;
                end
                else if (!used_reg && !carry_in.free_ok)
                begin
                    carry_next.free_ok = 1'b1;
                    free_idx_next      = MyIdx;
                end
            end
        end
    end

    // hold the token and the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            used_reg  <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (load_line)
            begin
                used_reg <= 1'b1;
            end
        end
    end

    // payload: free index, line store and evaluation pipeline
    always_ff @(posedge clk)
    begin
        free_idx_reg      <= free_idx_next;
        prod_reg          <= prod_next;
        value_reg         <= value_next;
        if (load_line)
        begin
            slope_reg <= item.slope;
            icpt_reg  <= item.intercept;
        end
        else if (raise_icpt)
        begin
            icpt_reg <= item.intercept;
        end
    end

    assign carry_out    = carry_reg;
    assign free_idx_out = free_idx_reg;

endmodule

@@ sv/dynamic_line_hull_max_query.sv @@
// Top level of the line hull maximum block: sequencer, output register and
// the chain of dlh_cell line cells. Depends on dlh_pkg and dlh_cell.
//
//  channel   | direction | tdata                                  | tuser
//  s_axis    | in        | slope, intercept, query_x (low first)  | operation
//  m_axis    | out       | best_value                             | empty_flag, full_flag
//
// Each item runs through these steps from acceptance to result: the MUL and
// ADD states evaluate every line in parallel, the INJECT state starts a token,
// which walks the cell chain one cell per cycle and is caught at the tail, the
// WRITE state writes a new line into its entry and DONE loads the output register.
// One item is worked on at a time; s_axis_tready is high only when idle, so a new
// item is not taken before the last one is through, and later still while m_axis stalls.
// The next item may be accepted while the last result waits in m_axis.
// Reset clears every valid bit at once; no clearing pass is needed.
module dynamic_line_hull_max_query #(
    parameter int LINE_CAPACITY = dlh_pkg::LineCapacityDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dlh_pkg::InDataW-1:0]   s_axis_tdata,  // slope, intercept, query_x, pad
    input  logic [dlh_pkg::InUserW-1:0]   s_axis_tuser,  // operation
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dlh_pkg::OutDataW-1:0]  m_axis_tdata,  // best_value
    output logic [dlh_pkg::OutUserW-1:0]  m_axis_tuser   // empty_flag, full_flag
);
    import dlh_pkg::*;

    localparam int IdxW = $clog2(LINE_CAPACITY);

    state_t              state_reg;
    state_t              state_next;
    item_t               item_reg;
    carry_t              chain [0:LINE_CAPACITY];
    logic [IdxW-1:0]     fidx  [0:LINE_CAPACITY];
    carry_t              tail_reg;
    logic [IdxW-1:0]     tail_idx_reg;
    logic                accept;
    logic                capture;
    logic                wr_en;
    logic                load_out;
    logic                out_valid_reg;
    logic [ValueW-1:0]   out_best_reg;
    logic                out_empty_reg;
    logic                out_full_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sequence one item through evaluation, walk, write and output
    always_comb
    begin
        state_next = state_reg;
        capture    = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_INJECT;
            ST_INJECT: state_next = ST_WALK;
            ST_WALK:
            begin
                if (chain[LINE_CAPACITY].valid)
                begin
                    capture    = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                wr_en = (item_reg.op == OP_INSERT) && !tail_reg.hit && tail_reg.free_ok;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // latch the accepted item and the token leaving the chain
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op        <= s_axis_tuser[0];
            item_reg.slope     <= s_axis_tdata[23:0];
            item_reg.intercept <= s_axis_tdata[70:24];
            item_reg.query_x   <= s_axis_tdata[94:71];
        end
        if (capture)
        begin
            tail_reg     <= chain[LINE_CAPACITY];
            tail_idx_reg <= fidx[LINE_CAPACITY];
        end
    end

    // inject the token at the head of the chain
    assign chain[0] = '{valid: (state_reg == ST_INJECT), hit: 1'b0, best: '0,
                        free_ok: 1'b0};
    assign fidx[0] = '0;

    // row of line cells
    for (genvar g = 0; g < LINE_CAPACITY; g++)
    begin : g_cell
        dlh_cell #(
            .LINE_CAPACITY (LINE_CAPACITY),
            .INDEX         (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .item         (item_reg),
            .wr_en        (wr_en),
            .wr_idx       (tail_idx_reg),
            .carry_in     (chain[g]),
            .free_idx_in  (fidx[g]),
            .carry_out    (chain[g+1]),
            .free_idx_out (fidx[g+1])
        );
    end

    // output register: hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (item_reg.op == OP_QUERY)
            begin
                out_best_reg  <= tail_reg.hit ? tail_reg.best : '0;
                out_empty_reg <= !tail_reg.hit;
                out_full_reg  <= 1'b0;
            end
            else
            begin
                out_best_reg  <= '0;
                out_empty_reg <= 1'b0;
                out_full_reg  <= !tail_reg.hit && !tail_reg.free_ok;
            end
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_best_reg;
    assign m_axis_tuser[0] = out_empty_reg;
    assign m_axis_tuser[1] = out_full_reg;

endmodule
